[rtl/rpfh_pkg.sv]
// ----------------------------------------------------------------------------
// Record packet framer package
// Shared types, constants and the hash step for the record packet framer.
// ----------------------------------------------------------------------------
package rpfh_pkg;

  localparam int unsigned PayloadBytesDefault = 128;
  localparam int unsigned FrameLen = 10;
  localparam int unsigned TrailerLen = 4;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [31:0] HashMul = 32'h5bd1_e995;
  localparam int unsigned HashShift = 15;
  localparam logic [7:0] TypeStatus = 8'h02;
  localparam logic [7:0] TypeRunner = 8'h01;
  localparam logic [7:0] StatusMark = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CONTROL_ID = 2'd0,
    CFG_HASH_KEY   = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]        runner_byte0;
    logic [7:0]        runner_byte1;
    logic [7:0]        runner_byte2;
    logic [31:0]       punch_time;
    logic [15:0]       battery_mv;
    logic signed [7:0] temperature;
    logic [7:0]        signal_quality;
    logic              last_record;
  } in_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       end_of_packet;
  } out_t;

  typedef struct packed {
    logic [FrameLen-1:0][7:0] frame;
    logic                     keep;
    logic                     last;
    logic                     first;
  } entry_t;

  function automatic logic [31:0] fold_byte(logic [31:0] h, logic [7:0] b);
    logic [31:0] x;
    logic [31:0] p;
    x = h ^ {24'd0, b};
    p = x * HashMul;
    return p ^ (p >> HashShift);
  endfunction

endpackage

[rtl/record_packet_framer_with_hash_top.sv]
// ----------------------------------------------------------------------------
// Record packet framer with keyed hash
// Frames punch records into ten-byte frames and closes packets with a hash.
// ----------------------------------------------------------------------------
// The first byte of a record passes through the queue and then the output
// register before it goes valid, when the serializer is idle.
// The serializer sends one output beat per cycle while the output is not
// stalled: ten frame bytes per record and four more for the hash trailer.
// A dropped record that does not close a packet is popped without a beat.
// Reset clears the config registers, the fill count, the queue and the serializer state; no clearing pass.
module record_packet_framer_with_hash_top #(
  parameter int unsigned PAYLOAD_BYTES = rpfh_pkg::PayloadBytesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rpfh_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rpfh_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rpfh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rpfh_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [15:0]      control_id_q, control_id_d;
  logic [31:0]      hash_key_q, hash_key_d;
  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  rpfh_pkg::entry_t push_entry;
  rpfh_pkg::entry_t head;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    control_id_d = control_id_q;
    hash_key_d = hash_key_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rpfh_pkg::CFG_CONTROL_ID: control_id_d = cfg_data_i[15:0];
        rpfh_pkg::CFG_HASH_KEY:   hash_key_d = cfg_data_i;
        default:                  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_id_q <= '0;
      hash_key_q <= '0;
    end else begin
      control_id_q <= control_id_d;
      hash_key_q <= hash_key_d;
    end
  end

  rpfh_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .control_id_i(control_id_q),
    .queue_full_i(full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  rpfh_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_entry),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  rpfh_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head),
    .pop_o      (pop),
    .hash_key_i (hash_key_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

[rtl/rpfh_front.sv]
// ----------------------------------------------------------------------------
// Record packet framer front end
// Accepts records, classifies them, builds the frame and tracks fill level.
// ----------------------------------------------------------------------------
module rpfh_front #(
  parameter int unsigned PAYLOAD_BYTES = rpfh_pkg::PayloadBytesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rpfh_pkg::in_t    in_data_i,
  input  logic [15:0]      control_id_i,
  input  logic             queue_full_i,
  output logic             push_o,
  output rpfh_pkg::entry_t entry_o
);

  localparam int unsigned CntW = $clog2(PAYLOAD_BYTES + 1);

  logic [CntW-1:0] count_q, count_d;
  logic [CntW:0]   count_next;
  logic            status;
  logic            keep;

  assign in_stall_o = queue_full_i;
  assign push_o = in_valid_i && !queue_full_i;

  assign count_next = {1'b0, count_q} + (CntW + 1)'(rpfh_pkg::FrameLen);
  assign keep = (count_next <= (CntW + 1)'(PAYLOAD_BYTES));
  assign status = (in_data_i.runner_byte0 == rpfh_pkg::StatusMark) &&
                  (in_data_i.runner_byte1 == rpfh_pkg::StatusMark);

  always_comb begin
    entry_o.keep = keep;
    entry_o.last = in_data_i.last_record;
    entry_o.first = (count_q == '0);
    entry_o.frame[1] = control_id_i[15:8];
    entry_o.frame[2] = control_id_i[7:0];
    if (status) begin
      entry_o.frame[0] = rpfh_pkg::TypeStatus;
      entry_o.frame[3] = in_data_i.battery_mv[15:8];
      entry_o.frame[4] = in_data_i.battery_mv[7:0];
      entry_o.frame[5] = in_data_i.signal_quality;
      entry_o.frame[6] = in_data_i.temperature;
      entry_o.frame[7] = 8'd0;
      entry_o.frame[8] = 8'd0;
      entry_o.frame[9] = 8'd0;
    end else begin
      entry_o.frame[0] = rpfh_pkg::TypeRunner;
      entry_o.frame[3] = in_data_i.runner_byte0;
      entry_o.frame[4] = in_data_i.runner_byte1;
      entry_o.frame[5] = in_data_i.runner_byte2;
      entry_o.frame[6] = in_data_i.punch_time[31:24];
      entry_o.frame[7] = in_data_i.punch_time[23:16];
      entry_o.frame[8] = in_data_i.punch_time[15:8];
      entry_o.frame[9] = in_data_i.punch_time[7:0];
    end
  end

  always_comb begin
    count_d = count_q;
    if (push_o) begin
      if (in_data_i.last_record) begin
        count_d = '0;
      end else if (keep) begin
        count_d = count_next[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

[rtl/rpfh_fifo.sv]
// ----------------------------------------------------------------------------
// Record packet framer queue
// Short queue of framed records between the front end and the serializer.
// ----------------------------------------------------------------------------
module rpfh_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rpfh_pkg::entry_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output rpfh_pkg::entry_t head_o
);

  localparam int unsigned PtrW = (rpfh_pkg::QueueDepth > 1) ? $clog2(rpfh_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(rpfh_pkg::QueueDepth + 1);

  rpfh_pkg::entry_t mem_q [rpfh_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o = (count_q == CntW'(rpfh_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(rpfh_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

endmodule

[rtl/rpfh_back.sv]
// ----------------------------------------------------------------------------
// Record packet framer back end
// Sends frame bytes one per beat, folds them into the hash, appends trailer.
// ----------------------------------------------------------------------------
module rpfh_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  rpfh_pkg::entry_t head_i,
  output logic             pop_o,
  input  logic [31:0]      hash_key_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rpfh_pkg::out_t   out_data_o
);

  localparam logic [3:0] LastFrameIdx = 4'(rpfh_pkg::FrameLen - 1);
  localparam logic [3:0] FirstTrailIdx = 4'(rpfh_pkg::FrameLen);
  localparam logic [3:0] LastTrailIdx = 4'(rpfh_pkg::FrameLen + rpfh_pkg::TrailerLen - 1);

  logic           started_q, started_d;
  logic [3:0]     idx_q, idx_d;
  logic [31:0]    hash_q, hash_d;
  logic           out_valid_q, out_valid_d;
  rpfh_pkg::out_t out_q, out_d;

  logic [3:0]  idx;
  logic        can_emit;
  logic        skip;
  logic        emit;
  logic        done;
  logic        in_frame;
  logic [31:0] hash_base;
  logic [7:0]  cur_byte;

  assign idx = started_q ? idx_q : (head_i.keep ? 4'd0 : FirstTrailIdx);
  assign can_emit = !out_valid_q || !out_stall_i;
  assign skip = !empty_i && !head_i.keep && !head_i.last;
  assign emit = !empty_i && !skip && can_emit;
  assign in_frame = (idx <= LastFrameIdx);
  assign done = (idx == LastTrailIdx) || ((idx == LastFrameIdx) && !head_i.last);
  assign pop_o = skip || (emit && done);
  assign hash_base = ((idx == '0) && head_i.first) ? hash_key_i : hash_q;

  always_comb begin
    unique case (idx)
      FirstTrailIdx:         cur_byte = hash_q[31:24];
      FirstTrailIdx + 4'd1:  cur_byte = hash_q[23:16];
      FirstTrailIdx + 4'd2:  cur_byte = hash_q[15:8];
      LastTrailIdx:          cur_byte = hash_q[7:0];
      default:               cur_byte = in_frame ? head_i.frame[idx] : 8'd0;
    endcase
  end

  always_comb begin
    started_d = started_q;
    idx_d = idx_q;
    hash_d = hash_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d.payload_byte = cur_byte;
      out_d.end_of_packet = (idx == LastTrailIdx);
      if (in_frame) begin
        hash_d = rpfh_pkg::fold_byte(hash_base, cur_byte);
      end
      if (done) begin
        started_d = 1'b0;
      end else begin
        started_d = 1'b1;
        idx_d = idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      started_q <= started_d;
      idx_q <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

[rtl/rpfh_checker.sv]
// ----------------------------------------------------------------------------
// Record packet framer port checker
// Checks output beat hold rules and reset values seen on the top-level ports.
// ----------------------------------------------------------------------------
module rpfh_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input rpfh_pkg::out_t out_data_o
);

  // A stalled beat stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // A stalled beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // Reset leaves no beat pending.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  // Reset empties the queue, so input is never stalled then.
  assert property (@(posedge clk_i) !rst_ni |=> !in_stall_o)
    else $error("input stalled during reset");

endmodule

bind record_packet_framer_with_hash_top rpfh_checker u_rpfh_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

[test/record_packet_framer_with_hash_top_tb.sv]
// ----------------------------------------------------------------------------
// Record packet framer with keyed hash testbench
// Sends punch records with random gaps against random output stalls and
// checks every payload beat, frame bytes and hash trailer, against a
// predictor that frames each record and folds each byte into the hash. A
// short directed table covers field extremes, status records, a full packet
// with dropped records and single-record packets. Random phases then follow,
// each after a change of the device id and the hash key.
// ----------------------------------------------------------------------------
module record_packet_framer_with_hash_top_tb;

  localparam int unsigned PayloadBytes = rpfh_pkg::PayloadBytesDefault;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned PhaseCount = 5;
  localparam int unsigned RecordsPerPhase = 86;
  localparam logic [rpfh_pkg::CfgIdxW-1:0] CfgIdxSpareLo = 2'd2;
  localparam logic [rpfh_pkg::CfgIdxW-1:0] CfgIdxSpareHi = 2'd3;

  typedef struct {
    rpfh_pkg::in_t rec;
    bit            typed;
    logic [79:0]   frame_bytes;
  } directed_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  rpfh_pkg::in_t                 in_data_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  rpfh_pkg::out_t                out_data_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [rpfh_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [rpfh_pkg::CfgDataW-1:0] cfg_data_i;

  logic [15:0]    device_id;
  logic [31:0]    key_value;
  logic [31:0]    running_hash;
  int unsigned    packet_fill;
  rpfh_pkg::out_t expected_payload[$];
  int unsigned    mismatch_count = 0;
  int unsigned    quiet_cycles = 0;
  bit             no_idling = 1'b0;

  record_packet_framer_with_hash_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic logic [31:0] mix_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] t;
    t = (acc ^ {24'd0, b}) * rpfh_pkg::HashMul;
    return t ^ (t >> rpfh_pkg::HashShift);
  endfunction

  function automatic void predict_record(input rpfh_pkg::in_t rec);
    logic [7:0]  frame [rpfh_pkg::FrameLen];
    logic [31:0] h;
    int unsigned k;
    if (packet_fill == 0) running_hash = key_value;
    if (packet_fill + rpfh_pkg::FrameLen <= PayloadBytes) begin
      frame[1] = device_id[15:8];
      frame[2] = device_id[7:0];
      if (rec.runner_byte0 == rpfh_pkg::StatusMark &&
          rec.runner_byte1 == rpfh_pkg::StatusMark) begin
        frame[0] = rpfh_pkg::TypeStatus;
        frame[3] = rec.battery_mv[15:8];
        frame[4] = rec.battery_mv[7:0];
        frame[5] = rec.signal_quality;
        frame[6] = rec.temperature;
        frame[7] = 8'h00;
        frame[8] = 8'h00;
        frame[9] = 8'h00;
      end else begin
        frame[0] = rpfh_pkg::TypeRunner;
        frame[3] = rec.runner_byte0;
        frame[4] = rec.runner_byte1;
        frame[5] = rec.runner_byte2;
        frame[6] = rec.punch_time[31:24];
        frame[7] = rec.punch_time[23:16];
        frame[8] = rec.punch_time[15:8];
        frame[9] = rec.punch_time[7:0];
      end
      for (k = 0; k < rpfh_pkg::FrameLen; k++) begin
        running_hash = mix_byte(running_hash, frame[k]);
        expected_payload.push_back(rpfh_pkg::out_t'({frame[k], 1'b0}));
      end
      packet_fill += rpfh_pkg::FrameLen;
    end
    if (rec.last_record) begin
      h = running_hash;
      for (k = 0; k < rpfh_pkg::TrailerLen; k++) begin
        expected_payload.push_back(
          rpfh_pkg::out_t'({h[31 - 8 * k -: 8], k == rpfh_pkg::TrailerLen - 1}));
      end
      packet_fill = 0;
      running_hash = key_value;
    end
  endfunction

  function automatic rpfh_pkg::in_t make_record(input logic [7:0] b0, input logic [7:0] b1,
                                                input logic [7:0] b2, input logic [31:0] ts,
                                                input logic [15:0] bat, input logic [7:0] temp,
                                                input logic [7:0] sq, input logic last);
    rpfh_pkg::in_t r;
    r.runner_byte0 = b0;
    r.runner_byte1 = b1;
    r.runner_byte2 = b2;
    r.punch_time = ts;
    r.battery_mv = bat;
    r.temperature = temp;
    r.signal_quality = sq;
    r.last_record = last;
    return r;
  endfunction

  function automatic rpfh_pkg::in_t random_record(input logic last);
    rpfh_pkg::in_t r;
    int unsigned   kind;
    kind = $urandom_range(0, 7);
    r = make_record(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), $urandom(),
                    16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), last);
    if (kind < 2) begin
      r.runner_byte0 = rpfh_pkg::StatusMark;
      r.runner_byte1 = rpfh_pkg::StatusMark;
    end else if (kind == 2) begin
      r.runner_byte0 = rpfh_pkg::StatusMark;
    end else if (kind == 3) begin
      r.runner_byte1 = rpfh_pkg::StatusMark;
    end
    return r;
  endfunction

  task automatic send_record(input rpfh_pkg::in_t rec, input bit typed,
                             input logic [79:0] frame_bytes);
    int unsigned base;
    int unsigned k;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i = rec;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_record(rec);
    if (typed) begin
      base = expected_payload.size() - rpfh_pkg::FrameLen;
      for (k = 0; k < rpfh_pkg::FrameLen; k++) begin
        expected_payload[base + k].payload_byte = frame_bytes[79 - 8 * k -: 8];
      end
    end
    if (!no_idling && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      in_data_i = random_record(1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
  endtask

  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_payload.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [rpfh_pkg::CfgIdxW-1:0] idx,
                                input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      rpfh_pkg::CFG_CONTROL_ID: begin
        device_id = value[15:0];
      end
      rpfh_pkg::CFG_HASH_KEY: begin
        key_value = value;
        if (packet_fill == 0) running_hash = value;
      end
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin : out_stall_gen
    int unsigned run_len;
    out_stall_i = 1'b0;
    forever begin
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      repeat (run_len) @(negedge clk_i);
      if (!no_idling) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_beats
    rpfh_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_payload.size() == 0) begin
        report_mismatch($sformatf("unexpected beat byte %h eop %b",
                                  out_data_o.payload_byte, out_data_o.end_of_packet));
      end else begin
        want = expected_payload.pop_front();
        if (out_data_o.payload_byte !== want.payload_byte) begin
          report_mismatch($sformatf("payload_byte got %h want %h",
                                    out_data_o.payload_byte, want.payload_byte));
        end
        if (out_data_o.end_of_packet !== want.end_of_packet) begin
          report_mismatch($sformatf("end_of_packet got %b want %b",
                                    out_data_o.end_of_packet, want.end_of_packet));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    directed_row_t directed_rows[$];
    int unsigned   packet_left;
    int unsigned   phase;
    int unsigned   n;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = rpfh_pkg::CFG_CONTROL_ID;
    cfg_data_i = '0;
    device_id = '0;
    key_value = '0;
    running_hash = '0;
    packet_fill = 0;
    packet_left = 0;

    directed_rows.push_back('{make_record(8'h00, 8'h00, 8'h00, 32'h0, 16'h0, 8'h00, 8'h00, 1'b0),
                              1'b1, 80'h01_00_00_00_00_00_00_00_00_00});
    directed_rows.push_back('{make_record(8'hFF, 8'hFE, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 8'h7F,
                                          8'hFF, 1'b0),
                              1'b1, 80'h01_00_00_FF_FE_FF_FF_FF_FF_FF});
    directed_rows.push_back('{make_record(8'hFE, 8'hFF, 8'h00, 32'h1234_5678, 16'h0, 8'h80,
                                          8'h00, 1'b0),
                              1'b1, 80'h01_00_00_FE_FF_00_12_34_56_78});
    directed_rows.push_back('{make_record(8'hFF, 8'hFF, 8'h5A, 32'hA5A5_A5A5, 16'hFFFF, 8'h80,
                                          8'hFF, 1'b0),
                              1'b1, 80'h02_00_00_FF_FF_FF_80_00_00_00});
    directed_rows.push_back('{make_record(8'hFF, 8'hFF, 8'h00, 32'h0, 16'h0, 8'h7F, 8'd99, 1'b0),
                              1'b1, 80'h02_00_00_00_00_63_7F_00_00_00});
    directed_rows.push_back('{make_record(8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 16'h1234, 8'hFF,
                                          8'h00, 1'b1),
                              1'b0, 80'h0});
    directed_rows.push_back('{make_record(8'h00, 8'hFF, 8'h00, 32'h8000_0000, 16'hFFFF, 8'h00,
                                          8'd99, 1'b1),
                              1'b0, 80'h0});
    // Twelve records fill the packet; the next two are dropped, the second one closing it.
    for (n = 0; n < 14; n++) begin
      directed_rows.push_back('{random_record(n == 13), 1'b0, 80'h0});
    end
    directed_rows.push_back('{random_record(1'b1), 1'b0, 80'h0});

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      send_record(directed_rows[i].rec, directed_rows[i].typed, directed_rows[i].frame_bytes);
    end

    for (phase = 0; phase < PhaseCount; phase++) begin
      drain_block();
      case (phase)
        0: begin
          write_register(CfgIdxSpareLo, $urandom());
          write_register(rpfh_pkg::CFG_CONTROL_ID, 32'hFFFF);
          write_register(rpfh_pkg::CFG_HASH_KEY, 32'hFFFF_FFFF);
          write_register(CfgIdxSpareHi, $urandom());
        end
        1: begin
          write_register(rpfh_pkg::CFG_HASH_KEY, 32'h0);
          write_register(rpfh_pkg::CFG_CONTROL_ID, 32'h0);
        end
        2: begin
          write_register(rpfh_pkg::CFG_CONTROL_ID, $urandom());
          write_register(rpfh_pkg::CFG_HASH_KEY, $urandom());
        end
        3: begin
          write_register(rpfh_pkg::CFG_HASH_KEY, $urandom());
          write_register(rpfh_pkg::CFG_CONTROL_ID, $urandom());
          write_register(CfgIdxSpareHi, $urandom());
        end
        default: begin
          write_register(rpfh_pkg::CFG_CONTROL_ID, $urandom());
          write_register(rpfh_pkg::CFG_HASH_KEY, 32'hFFFF_FFFF);
          no_idling = 1'b1;
        end
      endcase
      for (n = 0; n < RecordsPerPhase; n++) begin
        if (packet_left == 0) begin
          packet_left = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 16)
                                                     : $urandom_range(1, 11);
        end
        send_record(random_record(packet_left == 1), 1'b0, 80'h0);
        packet_left--;
      end
    end

    drain_block();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
